@@ design/brw_pkg.sv @@
// brw_pkg: shared types and constants of the base relocation walker
// result kinds, register indexes, parse phases and the result queue entry
// no dependencies
package brw_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 32;
    localparam int unsigned QueueDepth    = 8;
    localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

    localparam logic [CfgIndexWidth-1:0] REG_WIDE_IMAGE   = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_IMAGE_SIZE   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_DIR_START    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_DIR_SIZE     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_EMIT_PATCHES = 3'd4;

    localparam logic [11:0] OFS_MASK     = 12'hfff;
    localparam int unsigned TYPE_SHIFT   = 12;
    localparam logic [31:0] HDR_BYTES    = 32'd8;
    localparam logic [3:0]  TYPE_ABS     = 4'd0;
    localparam logic [3:0]  TYPE_HIGHLOW = 4'd3;
    localparam logic [3:0]  TYPE_DIR64   = 4'd10;

    typedef enum logic [1:0] {
        KIND_PATCH   = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_INVALID = 2'd2,
        KIND_UNSUP   = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        PH_PAGE_LO = 5'b00001,
        PH_PAGE_HI = 5'b00010,
        PH_SIZE_LO = 5'b00100,
        PH_SIZE_HI = 5'b01000,
        PH_ENTRY   = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] patch_address;
        logic        patch_wide;
        logic        last_of_run;
    } result_t;

endpackage

@@ design/base_relocation_walker.sv @@
// base_relocation_walker: parses a base relocation directory halfword by halfword
// and queues patch, done and error results; uses brw_pkg

// The walker takes one directory halfword per cycle while item_stall is low. A
// transfer is held in an input register, where header and entry checks run
// against the parse state, and its results (at most two: a patch and a closing
// done or error) go into an eight-entry result queue, so a result passes the
// input register and the result queue before it is valid at the output.
// The input side stalls only when the queue could not hold the results of the
// registered item and of one more; with the output side free the rate is one
// halfword per cycle, and the two results of a halfword leave the queue one
// after the other. The first error or the end of the directory halts the walk
// until a halfword marked first arrives.
module base_relocation_walker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [brw_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [brw_pkg::CfgDataWidth-1:0]     cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [15:0]                          half_word,
    input  logic                                 first,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [1:0]                           kind,
    output logic [31:0]                          patch_address,
    output logic                                 patch_wide,
    output logic                                 last_of_run
);

    localparam int unsigned PW = brw_pkg::QueuePtrWidth;

    // configuration
    logic        wide_image_reg;
    logic [31:0] image_size_reg;
    logic [31:0] dir_start_reg;
    logic [31:0] dir_size_reg;
    logic        emit_patches_reg;

    // input register
    logic        s1_valid_reg;
    logic [15:0] s1_half_reg;
    logic        s1_first_reg;

    // parse state
    brw_pkg::phase_t phase_reg, phase_next;
    logic [32:0] dir_offset_reg, dir_offset_next;
    logic [31:0] page_base_reg, page_base_next;
    logic [31:0] block_left_reg, block_left_next;
    logic [15:0] low_half_reg, low_half_next;
    logic        halted_reg, halted_next;

    // result queue
    brw_pkg::result_t       queue_reg [brw_pkg::QueueDepth];
    logic [PW-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]            count_reg, count_next;

    // per-item working values
    brw_pkg::phase_t eff_phase;
    logic [32:0] eff_offset;
    logic [31:0] eff_page;
    logic [31:0] eff_left;
    logic [15:0] eff_low;
    logic        eff_halted;
    logic [32:0] remaining;
    logic [32:0] room;
    logic [31:0] full_word;
    logic [3:0]  rel_type;
    logic [32:0] addr_sum;
    logic [31:0] addr;
    logic [3:0]  patch_bytes;
    logic [32:0] addr_end;
    logic [32:0] dir_end;
    logic        bad_bounds;
    logic        bad_overlap;
    logic [32:0] off_after;
    logic [32:0] rem_after;
    logic        fail;

    logic              push0, push1;
    brw_pkg::result_t  res0, res1;
    logic              pop;
    logic [PW:0]       push_count;
    logic [PW+1:0]     need;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_image_reg   <= 1'b0;
            image_size_reg   <= '0;
            dir_start_reg    <= '0;
            dir_size_reg     <= '0;
            emit_patches_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                brw_pkg::REG_WIDE_IMAGE:   wide_image_reg   <= cfg_data[0];
                brw_pkg::REG_IMAGE_SIZE:   image_size_reg   <= cfg_data;
                brw_pkg::REG_DIR_START:    dir_start_reg    <= cfg_data;
                brw_pkg::REG_DIR_SIZE:     dir_size_reg     <= cfg_data;
                brw_pkg::REG_EMIT_PATCHES: emit_patches_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // room for the registered item and one more, two results each
    always_comb
    begin
        need       = {1'b0, count_reg} + (s1_valid_reg ? (PW+2)'(4) : (PW+2)'(2));
        item_stall = need > (PW+2)'(brw_pkg::QueueDepth);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= item_valid && !item_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_half_reg  <= half_word;
            s1_first_reg <= first;
        end
    end

    // parse one halfword
    always_comb
    begin
        if (s1_first_reg)
        begin
            eff_phase  = brw_pkg::PH_PAGE_LO;
            eff_offset = '0;
            eff_page   = '0;
            eff_left   = '0;
            eff_low    = '0;
            eff_halted = 1'b0;
        end
        else
        begin
            eff_phase  = phase_reg;
            eff_offset = dir_offset_reg;
            eff_page   = page_base_reg;
            eff_left   = block_left_reg;
            eff_low    = low_half_reg;
            eff_halted = halted_reg;
        end

        remaining   = {1'b0, dir_size_reg} - eff_offset;
        room        = remaining + 33'd6;
        full_word   = {s1_half_reg, eff_low};
        rel_type    = s1_half_reg[15:brw_pkg::TYPE_SHIFT];
        addr_sum    = {1'b0, eff_page} + {21'd0, s1_half_reg[11:0] & brw_pkg::OFS_MASK};
        addr        = addr_sum[31:0];
        patch_bytes = wide_image_reg ? 4'd8 : 4'd4;
        addr_end    = {1'b0, addr} + {29'd0, patch_bytes};
        dir_end     = {1'b0, dir_start_reg} + {1'b0, dir_size_reg};
        bad_bounds  = addr_end > {1'b0, image_size_reg};
        bad_overlap = ({1'b0, addr} < dir_end) && (addr_end > {1'b0, dir_start_reg});
        off_after   = eff_offset + 33'd2;
        rem_after   = {1'b0, dir_size_reg} - off_after;

        phase_next      = eff_phase;
        dir_offset_next = eff_offset;
        page_base_next  = eff_page;
        block_left_next = eff_left;
        low_half_next   = eff_low;
        halted_next     = eff_halted;
        fail            = 1'b0;

        push0 = 1'b0;
        push1 = 1'b0;
        res0  = '{kind: brw_pkg::KIND_DONE, patch_address: '0, patch_wide: 1'b0,
                  last_of_run: 1'b1};
        res1  = '{kind: brw_pkg::KIND_DONE, patch_address: '0, patch_wide: 1'b0,
                  last_of_run: 1'b1};

        if (!s1_valid_reg)
        begin
            phase_next      = phase_reg;
            dir_offset_next = dir_offset_reg;
            page_base_next  = page_base_reg;
            block_left_next = block_left_reg;
            low_half_next   = low_half_reg;
            halted_next     = halted_reg;
        end
        else if (!eff_halted)
        begin
            if (eff_offset >= {1'b0, dir_size_reg})
            begin
                // directory exhausted: the halfword is not used
                push0       = 1'b1;
                res0.kind   = brw_pkg::KIND_DONE;
                halted_next = 1'b1;
                fail        = 1'b1;
            end
            else
            begin
                case (eff_phase)
                    brw_pkg::PH_PAGE_LO:
                    begin
                        if (remaining < {1'b0, brw_pkg::HDR_BYTES})
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            low_half_next = s1_half_reg;
                            phase_next    = brw_pkg::PH_PAGE_HI;
                        end
                    end
                    brw_pkg::PH_PAGE_HI:
                    begin
                        page_base_next = full_word;
                        phase_next     = brw_pkg::PH_SIZE_LO;
                    end
                    brw_pkg::PH_SIZE_LO:
                    begin
                        low_half_next = s1_half_reg;
                        phase_next    = brw_pkg::PH_SIZE_HI;
                    end
                    brw_pkg::PH_SIZE_HI:
                    begin
                        // size minus eight is odd exactly when size is odd
                        if (full_word < brw_pkg::HDR_BYTES || full_word[0]
                            || {1'b0, full_word} > room)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            block_left_next = full_word - brw_pkg::HDR_BYTES;
                            phase_next = (full_word != brw_pkg::HDR_BYTES)
                                         ? brw_pkg::PH_ENTRY : brw_pkg::PH_PAGE_LO;
                        end
                    end
                    default:
                    begin
                        if (addr_sum[32])
                        begin
                            fail = 1'b1;
                        end
                        else if (rel_type != brw_pkg::TYPE_ABS
                                 && !(rel_type == brw_pkg::TYPE_DIR64 && wide_image_reg)
                                 && !(rel_type == brw_pkg::TYPE_HIGHLOW && !wide_image_reg))
                        begin
                            push0       = 1'b1;
                            res0.kind   = brw_pkg::KIND_UNSUP;
                            halted_next = 1'b1;
                            fail        = 1'b1;
                        end
                        else if (rel_type != brw_pkg::TYPE_ABS && (bad_bounds || bad_overlap))
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            if (rel_type != brw_pkg::TYPE_ABS && emit_patches_reg)
                            begin
                                push0              = 1'b1;
                                res0.kind          = brw_pkg::KIND_PATCH;
                                res0.patch_address = addr;
                                res0.patch_wide    = wide_image_reg;
                            end
                            if (eff_left <= 32'd2)
                            begin
                                block_left_next = '0;
                                phase_next      = brw_pkg::PH_PAGE_LO;
                            end
                            else
                            begin
                                block_left_next = eff_left - 32'd2;
                                phase_next      = brw_pkg::PH_ENTRY;
                            end
                        end
                    end
                endcase

                if (fail && !halted_next)
                begin
                    // invalid image reported by a check above
                    push0       = 1'b1;
                    res0.kind   = brw_pkg::KIND_INVALID;
                    halted_next = 1'b1;
                end
                else if (!fail)
                begin
                    dir_offset_next = off_after;
                    if (phase_next == brw_pkg::PH_PAGE_LO
                        && (off_after >= {1'b0, dir_size_reg}
                            || rem_after < {1'b0, brw_pkg::HDR_BYTES}))
                    begin
                        // block closed at or just short of the directory end
                        halted_next = 1'b1;
                        if (push0)
                        begin
                            push1     = 1'b1;
                            res1.kind = (off_after >= {1'b0, dir_size_reg})
                                        ? brw_pkg::KIND_DONE : brw_pkg::KIND_INVALID;
                        end
                        else
                        begin
                            push0     = 1'b1;
                            res0.kind = (off_after >= {1'b0, dir_size_reg})
                                        ? brw_pkg::KIND_DONE : brw_pkg::KIND_INVALID;
                        end
                    end
                end
            end
        end

        res0.last_of_run = !push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= brw_pkg::PH_PAGE_LO;
            dir_offset_reg <= '0;
            page_base_reg  <= '0;
            block_left_reg <= '0;
            low_half_reg   <= '0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            dir_offset_reg <= dir_offset_next;
            page_base_reg  <= page_base_next;
            block_left_reg <= block_left_next;
            low_half_reg   <= low_half_next;
            halted_reg     <= halted_next;
        end
    end

    // result queue
    assign pop        = result_valid && !result_stall;
    assign push_count = {{PW{1'b0}}, push0} + {{PW{1'b0}}, push1};

    always_comb
    begin
        count_next = count_reg + push_count - {{PW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_count[PW-1:0];
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push1)
        begin
            queue_reg[wr_ptr_reg + PW'(1)] <= res1;
        end
    end

    assign result_valid  = count_reg != '0;
    assign kind          = queue_reg[rd_ptr_reg].kind;
    assign patch_address = queue_reg[rd_ptr_reg].patch_address;
    assign patch_wide    = queue_reg[rd_ptr_reg].patch_wide;
    assign last_of_run   = queue_reg[rd_ptr_reg].last_of_run;

endmodule
